// ===== hw/rtl/hbs_pkg.sv =====
// ----------------------------------------------------------------------------
// hbs_pkg: shared types and constants of the heartbeat supervisor
// Operation, status and mode codes, the queued command and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package hbs_pkg;

	localparam int NUM_SLOTS_DEF = 8;
	localparam int MAX_SLOTS     = 16;
	localparam int QUEUE_DEPTH   = 2;

	typedef enum logic [2:0] {
		OP_REGISTER   = 3'd0,
		OP_UNREGISTER = 3'd1,
		OP_REPORT     = 3'd2,
		OP_EVALUATE   = 3'd3,
		OP_START      = 3'd4,
		OP_READ_COMP  = 3'd5,
		OP_READ_STAT  = 3'd6,
		OP_UNKNOWN    = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_INVALID  = 3'd1,
		ST_EXISTS   = 3'd2,
		ST_NOSPACE  = 3'd3,
		ST_TIMEDOUT = 3'd4,
		ST_ALREADY  = 3'd5,
		ST_NOENTRY  = 3'd6,
		ST_REFUSED  = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		MODE_STOPPED = 2'd0,
		MODE_OK      = 2'd1,
		MODE_FAULTED = 2'd2
	} mode_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_SCAN = 1'b1
	} bk_state_t;

	// classified command, as held in the queue
	typedef struct packed {
		op_t         op;
		logic        slot_ok;   // handle below the slot count
		logic [3:0]  slot;
		logic        args_bad;  // zero tag or zero deadline
		logic [15:0] tag;
		logic [29:0] deadline;
		logic [31:0] now;
		logic        wd_ok;
	} cmd_t;

	typedef struct packed {
		status_t     status_code;
		logic [3:0]  slot_out;
		mode_t       supervisor_mode;
		logic        feed_watchdog;
		logic [15:0] new_warnings;
		logic        new_fault;
		logic [15:0] fault_tag;
		logic [4:0]  active_count;
		logic [31:0] tally_first;
		logic [31:0] tally_second;
		logic [31:0] elapsed_ms;
		logic        overdue;
	} rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hbs_if.sv =====
// ----------------------------------------------------------------------------
// hbs_cmd_if / hbs_rsp_if: command and result channels
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
`default_nettype none

interface hbs_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [3:0]  slot;
	logic [15:0] component_tag;
	logic [29:0] deadline_limit;
	logic [31:0] now_ms;
	logic        watchdog_ok;

	modport source (output valid, action, slot, component_tag, deadline_limit, now_ms,
		watchdog_ok, input ready);
	modport sink (input valid, action, slot, component_tag, deadline_limit, now_ms,
		watchdog_ok, output ready);
endinterface

interface hbs_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status_code;
	logic [3:0]  slot_out;
	logic [1:0]  supervisor_mode;
	logic        feed_watchdog;
	logic [15:0] new_warnings;
	logic        new_fault;
	logic [15:0] fault_tag;
	logic [4:0]  active_count;
	logic [31:0] tally_first;
	logic [31:0] tally_second;
	logic [31:0] elapsed_ms;
	logic        overdue;

	modport source (output valid, status_code, slot_out, supervisor_mode, feed_watchdog,
		new_warnings, new_fault, fault_tag, active_count, tally_first, tally_second,
		elapsed_ms, overdue, input ready);
	modport sink (input valid, status_code, slot_out, supervisor_mode, feed_watchdog,
		new_warnings, new_fault, fault_tag, active_count, tally_first, tally_second,
		elapsed_ms, overdue, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hbs_front.sv =====
// ----------------------------------------------------------------------------
// hbs_front: command intake
// Takes command transfers and classifies them into queued commands.
// ----------------------------------------------------------------------------
`default_nettype none

module hbs_front import hbs_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	hbs_cmd_if.sink cmd,
	input  wire     q_full,
	output logic    push,
	output cmd_t    push_data
);

	assign cmd.ready = !q_full;
	assign push      = cmd.valid && !q_full;

	always_comb begin
		push_data          = '0;
		push_data.op       = op_t'(cmd.action);
		push_data.slot     = cmd.slot;
		push_data.slot_ok  = {1'b0, cmd.slot} < 5'(NUM_SLOTS);
		push_data.args_bad = (cmd.component_tag == '0) || (cmd.deadline_limit == '0);
		push_data.tag      = cmd.component_tag;
		push_data.deadline = cmd.deadline_limit;
		push_data.now      = cmd.now_ms;
		push_data.wd_ok    = cmd.watchdog_ok;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/hbs_queue.sv =====
// ----------------------------------------------------------------------------
// hbs_queue: command queue
// Small FIFO between intake and execution.
// ----------------------------------------------------------------------------
`default_nettype none

module hbs_queue import hbs_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  push,
	input  cmd_t push_data,
	input  wire  pop,
	output logic full,
	output logic nonempty,
	output cmd_t head
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	cmd_t            mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [PW:0]     cnt_q;

	assign full     = cnt_q == (PW+1)'(QUEUE_DEPTH);
	assign nonempty = cnt_q != '0;
	assign head     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/hbs_back.sv =====
// ----------------------------------------------------------------------------
// hbs_back: command execution
// Slot table, supervisor state, one-slot-per-cycle scans and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hbs_back import hbs_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  wire      clk,
	input  wire      arst_n,
	input  wire      q_nonempty,
	input  cmd_t     q_head,
	output logic     pop,
	hbs_rsp_if.source rsp
);

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

	logic [15:0]        tags_q   [NUM_SLOTS];
	logic [29:0]        dl_q     [NUM_SLOTS];
	logic [31:0]        last_q   [NUM_SLOTS];
	logic [31:0]        rep_q    [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] used_q, warned_q;
	mode_t              mode_q, mode_d;
	logic [15:0]        owner_q, owner_d;
	logic [4:0]         total_q, total_d;
	logic [31:0]        feeds_q, feeds_d, faults_q, faults_d;

	bk_state_t          state_q, state_d;
	cmd_t               cmd_q;
	logic [IW-1:0]      idx_q;
	logic               free_q;
	logic [IW-1:0]      free_idx_q;
	logic [15:0]        warns_q;

	logic               rsp_vq;
	rsp_t               rsp_q, res;
	logic               fin, out_free;

	// write strobes
	logic               wr_reg, wr_unreg, wr_report, wr_start, wr_warn_set, wr_warn_clr;
	logic [IW-1:0]      wr_idx;

	cmd_t               c;
	logic [IW-1:0]      sel;
	logic [31:0]        el, d32, d3q, dhalf;
	logic               is_free, is_last;

	assign out_free = !rsp_vq || rsp.ready;
	assign c        = (state_q == BK_IDLE) ? q_head : cmd_q;
	assign sel      = (state_q == BK_IDLE) ? c.slot[IW-1:0] : idx_q;

	// elapsed time and warning thresholds at the selected slot
	assign el      = c.now - last_q[sel];
	assign d32     = {2'b00, dl_q[sel]};
	assign d3q     = ((d32 << 1) + d32) >> 2;
	assign dhalf   = d32 >> 1;
	assign is_free = !used_q[sel];
	assign is_last = idx_q == LAST_IDX;

	always_comb begin
		state_d     = state_q;
		pop         = 1'b0;
		fin         = 1'b0;
		res         = '0;
		mode_d      = mode_q;
		owner_d     = owner_q;
		total_d     = total_q;
		feeds_d     = feeds_q;
		faults_d    = faults_q;
		wr_reg      = 1'b0;
		wr_unreg    = 1'b0;
		wr_report   = 1'b0;
		wr_start    = 1'b0;
		wr_warn_set = 1'b0;
		wr_warn_clr = 1'b0;
		wr_idx      = sel;
		res.status_code = ST_OK;
		case (state_q)
			BK_IDLE: begin
				if (q_nonempty && out_free) begin
					pop = 1'b1;
					fin = 1'b1;
					case (c.op)
						OP_REGISTER: begin
							if (c.args_bad) begin
								res.status_code = ST_INVALID;
							end else begin
								fin     = 1'b0;
								state_d = BK_SCAN;
							end
						end
						OP_UNREGISTER: begin
							if (!c.slot_ok || is_free) begin
								res.status_code = ST_INVALID;
							end else begin
								wr_unreg = 1'b1;
								total_d  = total_q - 5'd1;
								if (owner_q == tags_q[sel]) begin
									owner_d = '0;
								end
							end
						end
						OP_REPORT: begin
							if (!c.slot_ok || is_free) begin
								res.status_code = ST_INVALID;
							end else begin
								wr_report = 1'b1;
							end
						end
						OP_EVALUATE: begin
							if (mode_q == MODE_STOPPED) begin
								res.status_code = ST_INVALID;
							end else begin
								fin     = 1'b0;
								state_d = BK_SCAN;
							end
						end
						OP_START: begin
							if (mode_q != MODE_STOPPED) begin
								res.status_code = ST_ALREADY;
							end else if (!c.wd_ok) begin
								res.status_code = ST_REFUSED;
							end else begin
								wr_start = 1'b1;
								mode_d   = MODE_OK;
							end
						end
						OP_READ_COMP: begin
							if (!c.slot_ok || is_free) begin
								res.status_code = ST_NOENTRY;
							end else begin
								res.tally_first  = rep_q[sel];
								res.tally_second = d32;
								res.elapsed_ms   = el;
								res.overdue      = el > d32;
							end
						end
						OP_READ_STAT: begin
							res.tally_first  = feeds_q;
							res.tally_second = faults_q;
						end
						default: begin
							res.status_code = ST_INVALID;
						end
					endcase
				end
			end
			BK_SCAN: begin
				if (c.op == OP_REGISTER) begin
					if (!is_free && tags_q[sel] == c.tag) begin
						fin = 1'b1;
						res.status_code = ST_EXISTS;
					end else if (is_last) begin
						fin = 1'b1;
						if (free_q || is_free) begin
							wr_reg       = 1'b1;
							wr_idx       = free_q ? free_idx_q : sel;
							total_d      = total_q + 5'd1;
							res.slot_out = 4'(wr_idx);
						end else begin
							res.status_code = ST_NOSPACE;
						end
					end
				end else begin
					// evaluate: stop at the first overdue slot
					res.new_warnings = warns_q;
					if (!is_free && el > d32) begin
						fin       = 1'b1;
						mode_d    = MODE_FAULTED;
						owner_d   = tags_q[sel];
						res.status_code = ST_TIMEDOUT;
						if (mode_q == MODE_OK) begin
							faults_d      = faults_q + 32'd1;
							res.new_fault = 1'b1;
						end
					end else begin
						if (!is_free) begin
							if (el > d3q && !warned_q[sel]) begin
								wr_warn_set = 1'b1;
								res.new_warnings[sel] = 1'b1;
							end else if (el <= dhalf) begin
								wr_warn_clr = 1'b1;
							end
						end
						if (is_last) begin
							fin     = 1'b1;
							mode_d  = MODE_OK;
							owner_d = '0;
							res.feed_watchdog = 1'b1;
							if (c.wd_ok && feeds_q != '1) begin
								feeds_d = feeds_q + 32'd1;
							end
						end
					end
				end
				if (fin) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
		res.supervisor_mode = mode_d;
		res.fault_tag       = owner_d;
		res.active_count    = total_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// slot payload: written only on registration, report and start
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= q_head;
		end
		if (wr_reg) begin
			dl_q[wr_idx]   <= c.deadline;
			last_q[wr_idx] <= c.now;
			rep_q[wr_idx]  <= '0;
		end
		if (wr_report) begin
			last_q[sel] <= c.now;
			if (rep_q[sel] != '1) begin
				rep_q[sel] <= rep_q[sel] + 32'd1;
			end
		end
		if (wr_start) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (used_q[i]) begin
					last_q[i] <= c.now;
				end
			end
		end
		if (fin) begin
			rsp_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				tags_q[i] <= '0;
			end
			used_q     <= '0;
			warned_q   <= '0;
			mode_q     <= MODE_STOPPED;
			owner_q    <= '0;
			total_q    <= '0;
			feeds_q    <= '0;
			faults_q   <= '0;
			idx_q      <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
			warns_q    <= '0;
			rsp_vq     <= 1'b0;
		end else begin
			mode_q   <= mode_d;
			owner_q  <= owner_d;
			total_q  <= total_d;
			feeds_q  <= feeds_d;
			faults_q <= faults_d;
			if (wr_reg) begin
				tags_q[wr_idx]   <= c.tag;
				used_q[wr_idx]   <= 1'b1;
				warned_q[wr_idx] <= 1'b0;
			end
			if (wr_unreg) begin
				tags_q[sel] <= '0;
				used_q[sel] <= 1'b0;
			end
			if (wr_warn_set) begin
				warned_q[sel] <= 1'b1;
			end
			if (wr_warn_clr) begin
				warned_q[sel] <= 1'b0;
			end
			if (state_q == BK_IDLE) begin
				idx_q   <= '0;
				free_q  <= 1'b0;
				warns_q <= '0;
			end else begin
				idx_q   <= idx_q + 1'b1;
				warns_q <= res.new_warnings;
				if (is_free && !free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= sel;
				end
			end
			if (fin) begin
				rsp_vq <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vq <= 1'b0;
			end
		end
	end

	assign rsp.valid           = rsp_vq;
	assign rsp.status_code     = rsp_q.status_code;
	assign rsp.slot_out        = rsp_q.slot_out;
	assign rsp.supervisor_mode = rsp_q.supervisor_mode;
	assign rsp.feed_watchdog   = rsp_q.feed_watchdog;
	assign rsp.new_warnings    = rsp_q.new_warnings;
	assign rsp.new_fault       = rsp_q.new_fault;
	assign rsp.fault_tag       = rsp_q.fault_tag;
	assign rsp.active_count    = rsp_q.active_count;
	assign rsp.tally_first     = rsp_q.tally_first;
	assign rsp.tally_second    = rsp_q.tally_second;
	assign rsp.elapsed_ms      = rsp_q.elapsed_ms;
	assign rsp.overdue         = rsp_q.overdue;

endmodule

`default_nettype wire

// ===== hw/rtl/multi_channel_heartbeat_supervisor.sv =====
// ----------------------------------------------------------------------------
// multi_channel_heartbeat_supervisor: software-watchdog heartbeat monitor
// Slot table of reporting components with deadline checks and feed requests.
// ----------------------------------------------------------------------------
// Each command transfer produces exactly one result transfer. Commands are
// classified on entry and held in a two-entry queue, so the command side keeps
// taking transfers until the queue is full while the execution side works or
// while a result waits in the output register. Unregister, report, start,
// both reads and rejected commands finish without a scan; register and
// evaluate walk the slot table one slot per cycle through a single shared
// compare path (register stops early at a tag already held, evaluate at the
// first overdue slot). All times are compared with 32-bit wrapping
// subtraction. There is no clearing pass after reset: the block takes
// commands at once.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_heartbeat_supervisor import hbs_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  wire       clk,
	input  wire       arst_n,
	hbs_cmd_if.sink   cmd,
	hbs_rsp_if.source rsp
);

	logic q_full, q_nonempty, push, pop;
	cmd_t push_data, q_head;

	// intake: classify and queue
	hbs_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
		.cmd       (cmd),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	hbs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (q_full),
		.nonempty  (q_nonempty),
		.head      (q_head)
	);

	// execution: slot table, scans, result register
	hbs_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_head     (q_head),
		.pop        (pop),
		.rsp        (rsp)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/hbs_checker.sv =====
// ----------------------------------------------------------------------------
// hbs_checker: port-level checks
// Result channel consistency, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hbs_checker import hbs_pkg::*; (
	input wire        clk,
	input wire        arst_n,
	input wire        rsp_valid,
	input wire        rsp_ready,
	input wire [2:0]  status_code,
	input wire [1:0]  supervisor_mode,
	input wire        feed_watchdog,
	input wire        new_fault,
	input wire [4:0]  active_count
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped before transfer");

	a_feed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && feed_watchdog |-> status_code == ST_OK && supervisor_mode == MODE_OK)
		else $error("feed request without healthy evaluate");

	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && new_fault |-> status_code == ST_TIMEDOUT
			&& supervisor_mode == MODE_FAULTED)
		else $error("new fault without timeout");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> active_count <= 5'(MAX_SLOTS))
		else $error("active count out of range");

endmodule

bind multi_channel_heartbeat_supervisor hbs_checker u_hbs_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.status_code     (rsp.status_code),
	.supervisor_mode (rsp.supervisor_mode),
	.feed_watchdog   (rsp.feed_watchdog),
	.new_fault       (rsp.new_fault),
	.active_count    (rsp.active_count)
);

`default_nettype wire
